### design/scss_pkg.sv
// Shared types and constants for the stride setter and step counter.
// Holds the request and result layouts, the mode states and the stride limits.
// Depends on nothing.
package scss_pkg;

  localparam int STRIDE_W    = 7;
  localparam int COUNT_W     = 32;
  localparam int BYTE_W      = 8;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 80;

  localparam logic [STRIDE_W-1:0] STRIDE_STEP = STRIDE_W'(5);
  localparam logic [STRIDE_W-1:0] STRIDE_MAX  = STRIDE_W'(95);

  // Request layout, first field in the highest bits
  typedef struct packed {
    logic [2:0]        pad;
    logic [BYTE_W-1:0] rx_byte;
    logic              rx_valid;
    logic              down_button;
    logic              enter_button;
    logic              up_button;
    logic              reset_button;
  } req_t;

  // Result layout, first field in the highest bits
  typedef struct packed {
    logic                counting;
    logic [COUNT_W-1:0]  distance_cm;
    logic [COUNT_W-1:0]  step_count;
    logic [STRIDE_W-1:0] stride_cm;
    logic [BYTE_W-1:0]   port_out;
  } res_t;

  typedef enum logic [7:0] {
    MS_START     = 8'b0000_0001,
    MS_INIT      = 8'b0000_0010,
    MS_WAIT      = 8'b0000_0100,
    MS_UPPRESS   = 8'b0000_1000,
    MS_INC       = 8'b0001_0000,
    MS_DOWNPRESS = 8'b0010_0000,
    MS_DEC       = 8'b0100_0000,
    MS_COUNT     = 8'b1000_0000
  } mode_t;

endpackage

### design/step_counter_stride_setter.sv
// Stride setter and step counter: mode machine, stride and counters, result skid.
// Depends on scss_pkg for the request and result layouts and the stride limits.
//
// Usage:
//   Each request on the s_axis channel is one tick carrying the four buttons,
//   a received-byte flag and the byte. The block answers every request with
//   exactly one result on the m_axis channel: the echoed byte (zero unless a
//   byte arrives while counting), the stride, the step count, the distance
//   and the counting flag.
//   A request's result is registered in the result register, or in the skid
//   register while the receiver stalls. Throughput is one request per cycle
//   while the skid register is empty; the mode machine, stride and counters
//   update in the same cycle the request is accepted, from adds and compares.
//   When the receiver stalls, one further result is parked in a skid register
//   and s_axis_tready falls only once that skid register is full. It rises
//   again the cycle after the receiver takes a result, so the result stream
//   keeps its full rate across a stall while the input waits.
//   rst (synchronous, active high) empties both result registers and puts the
//   machine in its start state with stride, steps and distance at zero.
module step_counter_stride_setter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [0] reset_button, [1] up_button, [2] enter_button, [3] down_button,
  // [4] rx_valid, [12:5] rx_byte, [15:13] zero
  input  logic [scss_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] port_out, [14:8] stride_cm, [46:15] step_count,
  // [78:47] distance_cm, [79] counting
  output logic [scss_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import scss_pkg::*;

  req_t                req;
  res_t                res_new;
  res_t                out_data;
  res_t                skid_data;
  logic                out_valid;
  logic                skid_valid;
  logic                accept;
  logic                out_free;

  mode_t               mode;
  mode_t               mode_next;
  logic [STRIDE_W-1:0] stride;
  logic [STRIDE_W-1:0] stride_next;
  logic [COUNT_W-1:0]  steps;
  logic [COUNT_W-1:0]  steps_next;
  logic [COUNT_W-1:0]  distance;
  logic [COUNT_W-1:0]  distance_next;
  logic [BYTE_W-1:0]   port_next;
  logic [STRIDE_W:0]   stride_sum;

  assign req           = req_t'(s_axis_tdata);
  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'(out_data);

  // Take the transition first
  always_comb begin
    mode_next = mode;
    case (mode)
      MS_START:     mode_next = MS_INIT;
      MS_INIT:      mode_next = MS_WAIT;
      MS_WAIT: begin
        if (req.enter_button) begin
          mode_next = MS_COUNT;
        end else if (req.up_button && !req.down_button) begin
          mode_next = MS_UPPRESS;
        end else if (!req.up_button && req.down_button) begin
          mode_next = MS_DOWNPRESS;
        end
      end
      MS_UPPRESS:   mode_next = req.up_button ? MS_UPPRESS : MS_INC;
      MS_INC:       mode_next = MS_WAIT;
      MS_DOWNPRESS: mode_next = req.down_button ? MS_DOWNPRESS : MS_DEC;
      MS_DEC:       mode_next = MS_WAIT;
      MS_COUNT:     mode_next = req.reset_button ? MS_INIT : MS_COUNT;
      default:      mode_next = MS_START;
    endcase
  end

  // Then act on the state just entered
  assign stride_sum = {1'b0, stride} + {1'b0, STRIDE_STEP};

  always_comb begin
    stride_next   = stride;
    steps_next    = steps;
    distance_next = distance;
    port_next     = '0;
    case (mode_next)
      MS_INIT: begin
        stride_next   = '0;
        steps_next    = '0;
        distance_next = '0;
      end
      MS_INC: begin
        if (stride < STRIDE_MAX) begin
          if (stride_sum > {1'b0, STRIDE_MAX}) begin
            stride_next = STRIDE_MAX;
          end else begin
            stride_next = stride_sum[STRIDE_W-1:0];
          end
        end
      end
      MS_DEC: begin
        if (stride >= STRIDE_STEP) begin
          stride_next = stride - STRIDE_STEP;
        end
      end
      MS_COUNT: begin
        if (req.rx_valid) begin
          port_next     = req.rx_byte;
          steps_next    = steps + COUNT_W'(1);
          distance_next = distance + COUNT_W'(stride);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_new.port_out    = port_next;
    res_new.stride_cm   = stride_next;
    res_new.step_count  = steps_next;
    res_new.distance_cm = distance_next;
    res_new.counting    = (mode_next == MS_COUNT);
  end

  // Advance the machine and registers on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MS_START;
      stride   <= '0;
      steps    <= '0;
      distance <= '0;
    end else if (accept) begin
      mode     <= mode_next;
      stride   <= stride_next;
      steps    <= steps_next;
      distance <= distance_next;
    end
  end

  // Result register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= res_new;
      end
    end else if (accept) begin
      skid_data <= res_new;
    end
  end

  // Skid entry only fills behind a held result
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid entry full while result register empty");

  // Stride stays within its limit
  assert property (@(posedge clk) disable iff (rst) stride <= STRIDE_MAX)
    else $error("stride above its maximum");

  // Echoed byte only appears while counting
  assert property (@(posedge clk) disable iff (rst)
      (out_valid && !out_data.counting) |-> (out_data.port_out == '0))
    else $error("byte echoed outside counting mode");

  // A stalled result holds while a new request parks in the skid entry
  assert property (@(posedge clk) disable iff (rst)
      (out_valid && !m_axis_tready && accept) |=> (skid_valid && $stable(out_data)))
    else $error("stalled result lost on skid fill");

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for step_counter_stride_setter: a directed table, then random
// button and byte requests, each result compared with a cycle-free model of the block.
// Depends on scss_pkg and the block's RTL only.

module testbench;
  import scss_pkg::*;

  localparam int RANDOM_REQS = 1700;
  localparam int CYCLE_LIMIT = 200000;
  localparam int CALM_FIRST  = 900;
  localparam int CALM_LAST   = 1150;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE      = 8;
  localparam int PRINT_CAP   = 40;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  step_counter_stride_setter i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // One row of the directed table: the request, and a typed reading where it is obvious
  typedef struct {
    req_t req;
    bit   fixed;
    res_t want;
  } plan_row_t;

  // Model state of the mode machine and counters
  mode_t               mode_q     = MS_START;
  logic [STRIDE_W-1:0] stride_q   = '0;
  logic [COUNT_W-1:0]  steps_q    = '0;
  logic [COUNT_W-1:0]  dist_q     = '0;
  logic                counting_q = 1'b0;

  res_t readings_q[$];

  int accepted      = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int cycles        = 0;
  int counted_steps = 0;
  int top_hits      = 0;
  int floor_hits    = 0;
  int sessions      = 0;
  int presses_left  = 0;
  int count_left    = 0;
  int hold_left     = 0;
  bit held          = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic req_t pack_req(input bit rb, input bit ub, input bit eb, input bit db,
                                    input bit rv, input logic [BYTE_W-1:0] b);
    req_t r;
    r              = '0;
    r.reset_button = rb;
    r.up_button    = ub;
    r.enter_button = eb;
    r.down_button  = db;
    r.rx_valid     = rv;
    r.rx_byte      = b;
    return r;
  endfunction

  function automatic res_t pack_res(input logic [BYTE_W-1:0] p, input logic [STRIDE_W-1:0] s,
                                    input logic [COUNT_W-1:0] n, input logic [COUNT_W-1:0] d,
                                    input logic c);
    res_t o;
    o.port_out    = p;
    o.stride_cm   = s;
    o.step_count  = n;
    o.distance_cm = d;
    o.counting    = c;
    return o;
  endfunction

  function automatic bit calm_window();
    return accepted >= CALM_FIRST && accepted < CALM_LAST;
  endfunction

  // Advance the mode machine by one tick, then apply the action of the new state
  function automatic res_t next_reading(input req_t r);
    res_t              o;
    logic [STRIDE_W:0] raised;
    o = '0;
    case (mode_q)
      MS_START: mode_q = MS_INIT;
      MS_INIT:  mode_q = MS_WAIT;
      MS_WAIT: begin
        if (r.enter_button) begin
          mode_q     = MS_COUNT;
          counting_q = 1'b1;
        end else if (r.up_button && !r.down_button) begin
          mode_q = MS_UPPRESS;
        end else if (!r.up_button && r.down_button) begin
          mode_q = MS_DOWNPRESS;
        end
      end
      MS_UPPRESS:   if (!r.up_button) mode_q = MS_INC;
      MS_DOWNPRESS: if (!r.down_button) mode_q = MS_DEC;
      MS_INC, MS_DEC: mode_q = MS_WAIT;
      MS_COUNT: begin
        if (r.reset_button) begin
          mode_q     = MS_INIT;
          counting_q = 1'b0;
        end
      end
      default: mode_q = MS_START;
    endcase

    case (mode_q)
      MS_INIT: begin
        stride_q = '0;
        steps_q  = '0;
        dist_q   = '0;
      end
      MS_INC: begin
        if (stride_q < STRIDE_MAX) begin
          raised   = {1'b0, stride_q} + STRIDE_STEP;
          stride_q = (raised > STRIDE_MAX) ? STRIDE_MAX : STRIDE_W'(raised);
          if (stride_q == STRIDE_MAX) top_hits++;
        end
      end
      MS_DEC: begin
        if (stride_q >= STRIDE_STEP) stride_q = stride_q - STRIDE_STEP;
        else floor_hits++;
      end
      MS_COUNT: begin
        if (r.rx_valid) begin
          o.port_out = r.rx_byte;
          steps_q    = steps_q + 1'b1;
          dist_q     = dist_q + COUNT_W'(stride_q);
          counted_steps++;
        end
      end
      default: ;
    endcase

    o.stride_cm   = stride_q;
    o.step_count  = steps_q;
    o.distance_cm = dist_q;
    o.counting    = counting_q;
    return o;
  endfunction

  // Mostly well-formed button sequences, chosen from the modelled mode, with some noise
  function automatic req_t pick_request();
    req_t r;
    int   roll;
    r    = pack_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), BYTE_W'($urandom));
    roll = $urandom_range(0, 99);
    // noise everywhere but in wait, where a stray enter would cut the session short
    if (mode_q != MS_WAIT && roll < 8) return r;
    case (mode_q)
      MS_START, MS_INIT: presses_left = $urandom_range(0, 60);
      MS_WAIT: begin
        if (presses_left == 0) begin
          r.enter_button = 1'b1;
          count_left     = $urandom_range(1, 60);
          sessions++;
        end else begin
          presses_left--;
          r.enter_button = 1'b0;
          r.up_button    = (roll < 75);
          r.down_button  = (roll < 5) || (roll >= 75);
        end
      end
      MS_UPPRESS:   r.up_button   = ($urandom_range(0, 99) < 40);
      MS_DOWNPRESS: r.down_button = ($urandom_range(0, 99) < 40);
      MS_COUNT: begin
        r.rx_valid     = ($urandom_range(0, 99) < 70);
        r.reset_button = (count_left == 0);
        if (count_left > 0) count_left--;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] got,
                                 input logic [COUNT_W-1:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("result %0d: %s got %0h want %0h", results_seen, what, got, want);
  endtask

  // Offer one request, wait for the handshake, log its reading, then idle for a random gap that may be zero
  task automatic issue(input req_t r, input bit fixed, input res_t want);
    res_t predicted;
    int   gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = next_reading(r);
    readings_q.push_back(fixed ? want : predicted);
    accepted++;
    gap = 0;
    while (!calm_window() && $urandom_range(0, 99) < 28) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= IN_TDATA_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender: reset, directed table, random requests, drain
  initial begin
    plan_row_t plan[25];
    plan = '{
      // start to init: everything clear
      '{pack_req(0, 0, 0, 0, 0, 8'h00), 1'b1, pack_res(8'h00, 0, 0, 0, 1'b0)},
      // init to wait, a byte outside counting is dropped
      '{pack_req(0, 0, 0, 0, 1, 8'hff), 1'b1, pack_res(8'h00, 0, 0, 0, 1'b0)},
      // up and down together: stay in wait
      '{pack_req(0, 1, 0, 1, 0, 8'h00), 1'b1, pack_res(8'h00, 0, 0, 0, 1'b0)},
      // reset outside counting is ignored
      '{pack_req(1, 0, 0, 0, 0, 8'h00), 1'b1, pack_res(8'h00, 0, 0, 0, 1'b0)},
      '{pack_req(0, 1, 0, 0, 0, 8'h00), 1'b0, '0},
      // held up, enter ignored while pressed
      '{pack_req(0, 1, 1, 0, 0, 8'h00), 1'b0, '0},
      '{pack_req(0, 0, 0, 0, 0, 8'h00), 1'b0, '0},
      '{pack_req(0, 0, 0, 1, 0, 8'h00), 1'b0, '0},
      '{pack_req(0, 0, 0, 1, 0, 8'h00), 1'b0, '0},
      '{pack_req(0, 0, 0, 0, 0, 8'h00), 1'b1, pack_res(8'h00, 0, 0, 0, 1'b0)},
      '{pack_req(0, 0, 0, 0, 0, 8'h00), 1'b0, '0},
      '{pack_req(0, 0, 0, 1, 0, 8'h00), 1'b0, '0},
      // decrement at zero leaves the stride alone
      '{pack_req(0, 0, 0, 0, 0, 8'h00), 1'b1, pack_res(8'h00, 0, 0, 0, 1'b0)},
      '{pack_req(0, 0, 0, 0, 0, 8'h00), 1'b0, '0},
      '{pack_req(0, 1, 0, 0, 0, 8'h00), 1'b0, '0},
      '{pack_req(0, 0, 0, 0, 0, 8'h00), 1'b0, '0},
      '{pack_req(0, 0, 0, 0, 0, 8'h00), 1'b0, '0},
      // enter wins over up and down
      '{pack_req(0, 1, 1, 1, 0, 8'h00), 1'b0, '0},
      // counting: other buttons ignored, bytes echoed
      '{pack_req(0, 1, 1, 1, 1, 8'hff), 1'b0, '0},
      '{pack_req(0, 0, 0, 0, 1, 8'h00), 1'b0, '0},
      '{pack_req(0, 0, 0, 0, 0, 8'haa), 1'b0, '0},
      // reset while counting goes back to init
      '{pack_req(1, 0, 0, 0, 1, 8'h07), 1'b1, pack_res(8'h00, 0, 0, 0, 1'b0)},
      '{pack_req(0, 0, 0, 0, 0, 8'h00), 1'b1, pack_res(8'h00, 0, 0, 0, 1'b0)},
      '{pack_req(0, 0, 1, 0, 1, 8'h81), 1'b0, '0},
      '{pack_req(1, 0, 0, 0, 0, 8'h00), 1'b1, pack_res(8'h00, 0, 0, 0, 1'b0)}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) issue(plan[i].req, plan[i].fixed, plan[i].want);
    repeat (RANDOM_REQS) issue(pick_request(), 1'b0, '0);
    s_axis_tvalid <= 1'b0;

    // drain, then let the pipeline settle
    while (readings_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d requests over %0d setting sessions, %0d bytes counted as steps.",
             accepted, sessions, counted_steps);
    $display("Stride reached its ceiling %0d times and was held at zero %0d times.",
             top_hits, floor_hits);
    if (mismatches == 0) begin
      $display("step_counter_stride_setter: match");
    end else begin
      $display("step_counter_stride_setter: mismatch");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off so the block backs up, a calm stretch
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!held && accepted >= HOLD_AT) begin
      held          <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm_window() || ($urandom_range(0, 99) >= 28);
    end
  end

  // Compare each result with the oldest pending reading
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata);
      results_seen++;
      if (readings_q.size() == 0) begin
        report_mismatch("unexpected result", COUNT_W'(m_axis_tdata), '0);
      end else begin
        want = readings_q.pop_front();
        if (got.port_out !== want.port_out)
          report_mismatch("port_out", COUNT_W'(got.port_out), COUNT_W'(want.port_out));
        if (got.stride_cm !== want.stride_cm)
          report_mismatch("stride_cm", COUNT_W'(got.stride_cm), COUNT_W'(want.stride_cm));
        if (got.step_count !== want.step_count)
          report_mismatch("step_count", got.step_count, want.step_count);
        if (got.distance_cm !== want.distance_cm)
          report_mismatch("distance_cm", got.distance_cm, want.distance_cm);
        if (got.counting !== want.counting)
          report_mismatch("counting", COUNT_W'(got.counting), COUNT_W'(want.counting));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d readings pending.", cycles,
               readings_q.size());
      $display("step_counter_stride_setter: mismatch");
      $finish;
    end
  end

endmodule

### step_counter_stride_setter.f
design/scss_pkg.sv
design/step_counter_stride_setter.sv
test/testbench.sv
